FILE: rtl/ucfc_pkg.sv
package ucfc_pkg;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_BUTTON  = 2'd2;

    localparam logic [7:0] START_BYTE  = 8'h41;
    localparam logic [7:0] CMD_TOGGLE1 = 8'h31;
    localparam logic [7:0] CMD_TOGGLE2 = 8'hD2;
    localparam logic [7:0] CMD_LIMITS  = 8'hD5;
    localparam logic [7:0] CMD_REPORT  = 8'hA1;

    localparam logic [2:0] LAST_BEAT = 3'd7;

    typedef struct packed {
        logic        report;
        logic [15:0] x;
        logic [15:0] y;
        logic        lvl_one;
        logic        lvl_two;
    } t_job;

endpackage

FILE: rtl/ucfc_front.sv
module ucfc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_opcode,
    input  logic [7:0]      i_rx_byte,
    input  logic [15:0]     i_accel_x,
    input  logic [15:0]     i_accel_y,
    input  logic            i_full,
    output logic            o_push,
    output ucfc_pkg::t_job  o_job
);
    import ucfc_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_CONFIG,
        PH_DATA
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_cfg, n_cfg;
    logic [15:0] r_data_lo, n_data_lo;
    logic [15:0] r_lim_x, n_lim_x;
    logic [15:0] r_lim_y, n_lim_y;
    logic        r_lvl_one, n_lvl_one;
    logic        r_lvl_two, n_lvl_two;

    logic        w_accept;
    logic        w_report;
    logic [16:0] w_mag_x;
    logic [16:0] w_mag_y;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    assign w_mag_x = i_accel_x[15] ? (17'h10000 - {1'b0, i_accel_x}) : {1'b0, i_accel_x};
    assign w_mag_y = i_accel_y[15] ? (17'h10000 - {1'b0, i_accel_y}) : {1'b0, i_accel_y};

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_cfg     = r_cfg;
        n_data_lo = r_data_lo;
        n_lim_x   = r_lim_x;
        n_lim_y   = r_lim_y;
        n_lvl_one = r_lvl_one;
        n_lvl_two = r_lvl_two;
        w_report  = 1'b0;
        if (w_accept) begin
            unique case (i_opcode)
                OP_RX_BYTE: begin
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (i_rx_byte == START_BYTE) begin
                                n_phase = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            n_cmd   = i_rx_byte;
                            n_cnt   = 2'd0;
                            n_phase = PH_CONFIG;
                        end
                        PH_CONFIG: begin
                            if (!r_cnt[0]) begin
                                n_cfg[7:0] = i_rx_byte;
                                n_cnt      = 2'd1;
                            end else begin
                                n_cfg[15:8] = i_rx_byte;
                                n_cnt       = 2'd0;
                                n_phase     = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (r_cnt == 2'd0) begin
                                n_data_lo[7:0] = i_rx_byte;
                            end
                            if (r_cnt == 2'd1) begin
                                n_data_lo[15:8] = i_rx_byte;
                            end
                            if (r_cnt == 2'd3) begin
                                n_cnt   = 2'd0;
                                n_phase = PH_HUNT;
                                priority if (r_cmd == CMD_TOGGLE1) begin
                                    n_lvl_one = !r_lvl_one;
                                end else if (r_cmd == CMD_TOGGLE2) begin
                                    n_lvl_two = !r_lvl_two;
                                end else if (r_cmd == CMD_LIMITS) begin
                                    n_lim_x = r_cfg;
                                    n_lim_y = r_data_lo;
                                end
                            end else begin
                                n_cnt = r_cnt + 2'd1;
                            end
                        end
                    endcase
                end
                OP_SAMPLE: begin
                    w_report = (w_mag_x > {1'b0, r_lim_x}) || (w_mag_y > {1'b0, r_lim_y});
                end
                OP_BUTTON: begin
                    n_lim_x = 16'h0000;
                    n_lim_y = 16'h0000;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_job.report  = w_report;
        o_job.x       = i_accel_x;
        o_job.y       = i_accel_y;
        o_job.lvl_one = n_lvl_one;
        o_job.lvl_two = n_lvl_two;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_cnt     <= 2'd0;
            r_lim_x   <= 16'h0000;
            r_lim_y   <= 16'h0000;
            r_lvl_one <= 1'b0;
            r_lvl_two <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_lim_x   <= n_lim_x;
            r_lim_y   <= n_lim_y;
            r_lvl_one <= n_lvl_one;
            r_lvl_two <= n_lvl_two;
        end
        r_cmd     <= n_cmd;
        r_cfg     <= n_cfg;
        r_data_lo <= n_data_lo;
    end

endmodule

FILE: rtl/ucfc_queue.sv
module ucfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ucfc_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ucfc_pkg::t_job  o_job
);
    import ucfc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
`endif

endmodule

FILE: rtl/ucfc_back.sv
module ucfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  ucfc_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_data,
    output logic            o_user,
    output logic            o_last
);
    import ucfc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_beat, n_beat;
    t_job        r_job, n_job;
    logic        r_valid, n_valid;
    logic [15:0] r_data, n_data;
    logic        r_user, n_user;
    logic        r_last, n_last;

    logic        w_adv;
    logic        w_final;
    logic [7:0]  w_byte;

    assign w_adv   = !r_valid || i_ready;
    assign w_final = !r_job.report || (r_beat == LAST_BEAT);

    always_comb begin
        unique case (r_beat)
            3'd0:    w_byte = START_BYTE;
            3'd1:    w_byte = CMD_REPORT;
            3'd4:    w_byte = r_job.y[7:0];
            3'd5:    w_byte = r_job.y[15:8];
            3'd6:    w_byte = r_job.x[7:0];
            3'd7:    w_byte = r_job.x[15:8];
            default: w_byte = 8'h00;
        endcase
        if (!r_job.report) begin
            w_byte = 8'h00;
        end
    end

    always_comb begin
        n_state = r_state;
        n_beat  = r_beat;
        n_job   = r_job;
        n_valid = r_valid && !i_ready;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_beat  = 3'd0;
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_adv) begin
                    n_valid = 1'b1;
                    n_data  = {6'b0, r_job.lvl_two, r_job.lvl_one, w_byte};
                    n_user  = r_job.report;
                    n_last  = w_final;
                    if (w_final) begin
                        n_beat = 3'd0;
                        if (!i_empty) begin
                            o_pop = 1'b1;
                            n_job = i_job;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_beat = r_beat + 3'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_beat  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
            r_valid <= n_valid;
        end
        r_job  <= n_job;
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

`ifndef NO_ASSERTIONS
    a_idle_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_user) |-> (o_last && (o_data[7:0] == 8'h00)))
        else $error("idle result not a single zero transfer");
    a_frame_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_user && !o_last && i_ready) |=> (o_valid && o_user))
        else $error("report frame broken by a gap");
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_beat == 3'd0))
        else $error("beat count left running while idle");
`endif

endmodule

FILE: rtl/uart_command_frame_controller.sv
// Serial command-frame controller with accelerometer threshold reporting.
// Input channel (s_axis): one transfer per item; tuser carries the opcode
// (received byte, accelerometer sample, button press), tdata the byte and
// the two signed sample axes. Output channel (m_axis): one transfer per
// result; tuser marks a frame byte, tdata carries the byte and both
// indicator levels, tlast marks the final result of an item.
// A reporting sample gives an 8-transfer frame, every other item gives one
// transfer with tuser low. The front parser and threshold compare take one
// item per cycle while the queue is not full; the back sequencer emits one
// result per cycle while the receiver is ready. An item's first result goes
// through the job queue, the back job register and the output register.
// A QUEUE_DEPTH-entry job queue sits between front and back; s_axis_tready
// drops only when it is full. When the receiver stalls, the output register
// holds its transfer, the back end halts and the queue absorbs items.
// Reset clears the parser, both thresholds, both indicators, the queue and
// the output register.
module uart_command_frame_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], accel_x[23:8], accel_y[39:24]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // tx_byte[7:0], indicator_one[8], indicator_two[9]
    output logic        m_axis_tuser,   // tx_valid[0]
    output logic        m_axis_tlast
);
    import ucfc_pkg::*;

    logic w_full;
    logic w_push;
    logic w_empty;
    logic w_pop;
    t_job w_front_job;
    t_job w_queue_job;

    ucfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_opcode  (s_axis_tuser),
        .i_rx_byte (s_axis_tdata[7:0]),
        .i_accel_x (s_axis_tdata[23:8]),
        .i_accel_y (s_axis_tdata[39:24]),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_job     (w_front_job)
    );

    ucfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_queue_job)
    );

    ucfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_queue_job),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

FILE: tb/tb_uart_command_frame_controller.sv
`timescale 1ns / 1ps

module tb_uart_command_frame_controller;
    import ucfc_pkg::*;

    localparam logic [7:0] CMD_IGNORED = 8'hD4;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    typedef enum logic [1:0] {
        SEEK_START,
        TAKE_CMD,
        TAKE_CFG,
        TAKE_DATA
    } t_parse;

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic       ind_one;
        logic       ind_two;
    } t_transfer;

    class uart_frame_tracker;
        t_parse      phase;
        logic [1:0]  byte_idx;
        logic [7:0]  cmd;
        logic [15:0] cfg;
        logic [31:0] data;
        logic [15:0] thr_x;
        logic [15:0] thr_y;
        logic        led_one;
        logic        led_two;
        t_transfer   frame_bytes_due[$];
        int          mismatches;
        int          checked;
        int          reports;

        function new();
            phase      = SEEK_START;
            byte_idx   = 2'd0;
            cmd        = 8'h00;
            cfg        = 16'h0000;
            data       = 32'h0;
            thr_x      = 16'h0000;
            thr_y      = 16'h0000;
            led_one    = 1'b0;
            led_two    = 1'b0;
            mismatches = 0;
            checked    = 0;
            reports    = 0;
        endfunction

        function automatic logic [16:0] magnitude(logic [15:0] v);
            return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        endfunction

        function automatic void push(logic vld, logic [7:0] b, logic lst);
            t_transfer t;
            t.tx_valid = vld;
            t.tx_byte  = b;
            t.last     = lst;
            t.ind_one  = led_one;
            t.ind_two  = led_two;
            frame_bytes_due.push_back(t);
        endfunction

        function automatic void absorb_item(logic [1:0] op, logic [7:0] rx,
                                            logic [15:0] ax, logic [15:0] ay);
            logic [7:0] frame [8];
            if (op == OP_RX_BYTE) begin
                case (phase)
                    SEEK_START: begin
                        if (rx == START_BYTE) phase = TAKE_CMD;
                    end
                    TAKE_CMD: begin
                        cmd      = rx;
                        byte_idx = 2'd0;
                        phase    = TAKE_CFG;
                    end
                    TAKE_CFG: begin
                        if (!byte_idx[0]) begin
                            cfg[7:0] = rx;
                            byte_idx = 2'd1;
                        end else begin
                            cfg[15:8] = rx;
                            byte_idx  = 2'd0;
                            phase     = TAKE_DATA;
                        end
                    end
                    default: begin
                        data[8*byte_idx +: 8] = rx;
                        if (byte_idx == 2'd3) begin
                            byte_idx = 2'd0;
                            phase    = SEEK_START;
                            if (cmd == CMD_TOGGLE1) begin
                                led_one = ~led_one;
                            end else if (cmd == CMD_TOGGLE2) begin
                                led_two = ~led_two;
                            end else if (cmd == CMD_LIMITS) begin
                                thr_x = cfg;
                                thr_y = data[15:0];
                            end
                        end else begin
                            byte_idx = byte_idx + 2'd1;
                        end
                    end
                endcase
            end else if (op == OP_BUTTON) begin
                thr_x = 16'h0000;
                thr_y = 16'h0000;
            end else if (op == OP_SAMPLE) begin
                if (magnitude(ax) > {1'b0, thr_x} || magnitude(ay) > {1'b0, thr_y}) begin
                    frame[0] = START_BYTE;
                    frame[1] = CMD_REPORT;
                    frame[2] = 8'h00;
                    frame[3] = 8'h00;
                    frame[4] = ay[7:0];
                    frame[5] = ay[15:8];
                    frame[6] = ax[7:0];
                    frame[7] = ax[15:8];
                    for (int k = 0; k < 8; k++) push(1'b1, frame[k], k == 7);
                    return;
                end
            end
            push(1'b0, 8'h00, 1'b1);
        endfunction

        function automatic void compare_transfer(logic tuser, logic [15:0] tdata,
                                                 logic tlast);
            t_transfer t;
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected transfer: tx_valid=%0d tx_byte=%02h last=%0d",
                       tuser, tdata[7:0], tlast);
                mismatches++;
                return;
            end
            t = frame_bytes_due.pop_front();
            checked++;
            if (t.tx_valid && t.last) reports++;
            if (tuser !== t.tx_valid) begin
                $error("tx_valid: expected %0d actual %0d", t.tx_valid, tuser);
                mismatches++;
            end
            if (tdata[7:0] !== t.tx_byte) begin
                $error("tx_byte: expected %02h actual %02h", t.tx_byte, tdata[7:0]);
                mismatches++;
            end
            if (tlast !== t.last) begin
                $error("last: expected %0d actual %0d", t.last, tlast);
                mismatches++;
            end
            if (tdata[8] !== t.ind_one) begin
                $error("indicator_one: expected %0d actual %0d", t.ind_one, tdata[8]);
                mismatches++;
            end
            if (tdata[9] !== t.ind_two) begin
                $error("indicator_two: expected %0d actual %0d", t.ind_two, tdata[9]);
                mismatches++;
            end
        endfunction

        function automatic int pending();
            return frame_bytes_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // rx_byte[7:0], accel_x[23:8], accel_y[39:24]
    logic [1:0]  s_axis_tuser = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // tx_byte[7:0], indicator_one[8], indicator_two[9]
    logic        m_axis_tuser;        // tx_valid[0]
    logic        m_axis_tlast;

    uart_frame_tracker tracker = new();
    int burst_left = 0;
    int items_sent = 0;
    int stall_mode = 0;
    int mode_left = 0;

    uart_command_frame_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // vary the receiver between free flow, random stalls and long periodic stalls
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 9) != 0);
            default: m_axis_tready <= ((mode_left % 24) >= 16);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.compare_transfer(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                             input logic [15:0] ax, input logic [15:0] ay);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ay, ax, rx};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.absorb_item(op, rx, ax, ay);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_RX_BYTE, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay);
        send_item(OP_SAMPLE, 8'($urandom), ax, ay);
    endtask

    task automatic send_other(input logic [1:0] op);
        send_item(op, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] cfg,
                              input logic [31:0] data);
        send_byte(START_BYTE);
        send_byte(cmd);
        send_byte(cfg[7:0]);
        send_byte(cfg[15:8]);
        for (int k = 0; k < 4; k++) send_byte(data[8*k +: 8]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2000));
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'h7FFF;
                    2: return 16'h8000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(0, 40000));
        endcase
    endfunction

    // land near the threshold so the strict compare is hit from both sides
    function automatic logic [15:0] pick_axis(logic [15:0] thr);
        logic [16:0] m;
        logic [15:0] v;
        if ($urandom_range(0, 2) == 0) return 16'($urandom);
        m = {1'b0, thr} + 17'($urandom_range(0, 2)) - 17'd1;
        if (m > 17'd32768) m = 17'd32768;
        v = m[15:0];
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    initial begin
        logic [7:0]  cmd;
        logic [15:0] cfg;
        logic [31:0] data;
        int          pick;
        bit          drained_mid;

        drained_mid = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0001);
        send_sample(16'h0000, 16'h7FFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(CMD_TOGGLE1, 16'h0000, 32'h0000_0000);
        send_frame(CMD_LIMITS, 16'hFFFF, 32'hFFFF_FFFF);
        send_sample(16'h8000, 16'h8000);
        send_other(OP_SPARE);
        send_other(OP_BUTTON);
        send_sample(16'h8000, 16'h8000);

        while (items_sent < 310) begin
            if (!drained_mid && items_sent > 155) begin
                wait_drained();
                drained_mid = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                case ($urandom_range(0, 5))
                    0: cmd = CMD_TOGGLE1;
                    1: cmd = CMD_TOGGLE2;
                    2, 3: cmd = CMD_LIMITS;
                    4: cmd = CMD_IGNORED;
                    default: cmd = 8'($urandom);
                endcase
                cfg  = pick_limit();
                data = {16'($urandom), pick_limit()};
                send_frame(cmd, cfg, data);
            end else if (pick < 80) begin
                send_sample(pick_axis(tracker.thr_x), pick_axis(tracker.thr_y));
            end else if (pick < 88) begin
                send_byte(8'($urandom));
            end else if (pick < 94) begin
                send_other(OP_BUTTON);
            end else if (pick < 97) begin
                send_other(OP_SPARE);
            end else begin
                // drop a frame partway; following items land in its fields
                send_byte(START_BYTE);
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items (bytes, frames, samples, buttons, spare opcode);",
                 items_sent);
        $display("checked %0d output transfers including %0d sensor report frames.",
                 tracker.checked, tracker.reports);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
